/* rtl/tcw_pkg.sv */
// tcw_pkg: shared types and constants of the text console writer
// no dependencies; used by tcw_seq, text_console_writer and the testbench
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // screen geometry defaults
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int INDEX_W = 11;
    localparam int ATTR_W  = 8;
    localparam int WORD_W  = 16;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST_PRT  = 8'h7F;

    // attribute of blank cells right after reset
    localparam logic [ATTR_W-1:0] RESET_BLANK_ATTR = 8'h0F;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // one result beat
    typedef struct packed {
        logic [WORD_W-1:0]  cell_word;
        logic [INDEX_W-1:0] cursor_pos;
        logic               scrolled;
    } t_result;

endpackage : tcw_pkg

`default_nettype wire

/* rtl/text_console_writer.sv */
// text_console_writer: top level, handshakes, blank attribute register, output register
// depends on tcw_pkg and tcw_seq
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | in        | i_in_valid/o_in_stall | op, char_code, back_color, fore_color, index
//  out     | out       | o_out_valid/i_out_stall | cell_word, cursor_pos, scrolled
//  cfg     | in        | i_cfg_valid/o_cfg_ready | blank attribute byte
//
// after reset the screen ram is swept to blank cells, input stalled.
// a put or a read holds the input through its work state and S_DONE; an unused op only through S_DONE.
// the result register loads on the edge that reopens the input.
// a clear writes every cell, one ram write per cycle.
// a put that scrolls then passes S_SCR_PRIME, S_SCR_COPY and S_SCR_BLANK: one ram port pair copies one cell a cycle.
// input is stalled while an item is in work and while its result waits on a full output register.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [COLOR_W-1:0] i_back_color,
    input  wire logic [COLOR_W-1:0] i_fore_color,
    input  wire logic [INDEX_W-1:0] i_cell_index,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [WORD_W-1:0]       o_cell_word,
    output logic [INDEX_W-1:0]      o_cursor_pos,
    output logic                    o_scrolled,
    // configuration channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [ATTR_W-1:0]  i_cfg_data
);

    logic [ATTR_W-1:0] r_blank_attr;
    logic              r_out_valid;
    t_result           r_out;

    logic              seq_idle;
    logic              res_valid;
    logic              res_take;
    t_result           res;

    // blank attribute register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= RESET_BLANK_ATTR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blank_attr <= i_cfg_data;
        end
    end

    // sequencer
    assign o_in_stall = !seq_idle;

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (i_in_valid && seq_idle),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_back_color (i_back_color),
        .i_fore_color (i_fore_color),
        .i_cell_index (i_cell_index),
        .i_blank_attr (r_blank_attr),
        .o_idle       (seq_idle),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    // output register, loads when empty or when its beat leaves
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_word  = r_out.cell_word;
    assign o_cursor_pos = r_out.cursor_pos;
    assign o_scrolled   = r_out.scrolled;

endmodule : text_console_writer

`default_nettype wire

/* rtl/tcw_ram.sv */
// tcw_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule : tcw_ram

`default_nettype wire

/* rtl/tcw_seq.sv */
// tcw_seq: sequencer with the shared address walker that drives the screen ram
// depends on tcw_pkg and tcw_ram
`timescale 1ns / 1ps
`default_nettype none

module tcw_seq
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item from the input channel
    input  wire logic               i_accept,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [COLOR_W-1:0] i_back_color,
    input  wire logic [COLOR_W-1:0] i_fore_color,
    input  wire logic [INDEX_W-1:0] i_cell_index,
    input  wire logic [ATTR_W-1:0]  i_blank_attr,
    output logic                    o_idle,
    // result toward the output register
    output logic                    o_res_valid,
    input  wire logic               i_res_take,
    output t_result                 o_res
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COPY_N = COLUMNS * (ROWS - 1);
    localparam int AW     = $clog2(CELLS);
    localparam int LW     = $clog2(CELLS + 1);
    localparam int CW     = $clog2(COLUMNS);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_READ,
        S_CLEAR,
        S_SCR_PRIME,
        S_SCR_COPY,
        S_SCR_BLANK,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_addr;
    logic [CW-1:0]         r_col;
    logic [LW-1:0]         r_lin;
    logic [CHAR_W-1:0]     r_char;
    logic [ATTR_W-1:0]     r_attr;
    logic                  r_idx_ok;
    logic [WORD_W-1:0]     r_word;
    logic                  r_scrolled;

    logic [CW-1:0]         n_col;
    logic [LW-1:0]         n_lin;
    logic                  printable;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;
    logic [LW-1:0]         copy_src;

    // character class of the latched put
    assign printable = (r_char >= CH_SPACE) && (r_char <= CH_LAST_PRT);

    // cursor update for a put, linear position kept alongside the column
    always_comb begin
        n_col = r_col;
        n_lin = r_lin;
        priority if (r_char == CH_BACKSPACE && r_col != '0) begin
            n_col = r_col - CW'(1);
            n_lin = r_lin - LW'(1);
        end else if (r_char == CH_RETURN) begin
            n_col = '0;
            n_lin = r_lin - LW'(r_col);
        end else if (r_char == CH_LINEFEED) begin
            n_col = '0;
            n_lin = r_lin - LW'(r_col) + LW'(COLUMNS);
        end else if (printable) begin
            n_col = (r_col == CW'(COLUMNS - 1)) ? '0 : r_col + CW'(1);
            n_lin = r_lin + LW'(1);
        end else begin
            n_col = r_col;
            n_lin = r_lin;
        end
    end

    // ram port steering
    assign copy_src = LW'(r_addr) + LW'(COLUMNS) + ((r_state == S_SCR_COPY) ? LW'(1) : LW'(0));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {i_blank_attr, CH_SPACE};
        ram_raddr = '0;
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {RESET_BLANK_ATTR, CH_SPACE};
            end
            S_IDLE: begin
                ram_raddr = AW'(i_cell_index);
            end
            S_PUT: begin
                ram_we    = printable;
                ram_waddr = AW'(r_lin);
                ram_wdata = {r_attr, r_char};
            end
            S_CLEAR, S_SCR_BLANK: begin
                ram_we = 1'b1;
            end
            S_SCR_PRIME: begin
                ram_raddr = AW'(copy_src);
            end
            S_SCR_COPY: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_raddr = AW'(copy_src);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer state, walker and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_col   <= '0;
            r_lin   <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(CELLS - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_accept) begin
                        r_char     <= i_char_code;
                        r_attr     <= {i_back_color, i_fore_color};
                        r_idx_ok   <= (32'(i_cell_index) < CELLS);
                        r_word     <= '0;
                        r_scrolled <= 1'b0;
                        r_addr     <= '0;
                        unique case (t_op'(i_op))
                            OP_PUT:   r_state <= S_PUT;
                            OP_CLEAR: r_state <= S_CLEAR;
                            OP_READ:  r_state <= S_READ;
                            OP_NONE:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_PUT: begin
                    r_col <= n_col;
                    if (n_lin >= LW'(CELLS)) begin
                        r_lin      <= LW'(COPY_N);
                        r_scrolled <= 1'b1;
                        r_state    <= S_SCR_PRIME;
                    end else begin
                        r_lin   <= n_lin;
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_word  <= r_idx_ok ? ram_rdata : '0;
                    r_state <= S_DONE;
                end
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(CELLS - 1)) begin
                        r_addr  <= '0;
                        r_col   <= '0;
                        r_lin   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_SCR_PRIME: begin
                    r_state <= S_SCR_COPY;
                end
                S_SCR_COPY: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(COPY_N - 1)) begin
                        r_state <= S_SCR_BLANK;
                    end
                end
                S_SCR_BLANK: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(CELLS - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result beat
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{cell_word: r_word, cursor_pos: INDEX_W'(r_lin), scrolled: r_scrolled};

endmodule : tcw_seq

`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for the text console writer (80x25 cell store and cursor)
// depends on tcw_pkg and text_console_writer; a built-in screen predictor checks every result
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int unsigned RUN_LIMIT_NS = 40_000_000;
    localparam int unsigned LONG_HOLD    = 120;

    // dut ports
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op         = '0;
    logic [CHAR_W-1:0]    i_char_code  = '0;
    logic [COLOR_W-1:0]   i_back_color = '0;
    logic [COLOR_W-1:0]   i_fore_color = '0;
    logic [INDEX_W-1:0]   i_cell_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [WORD_W-1:0]    o_cell_word;
    logic [INDEX_W-1:0]   o_cursor_pos;
    logic                 o_scrolled;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [ATTR_W-1:0]    i_cfg_data   = '0;

    // predicted screen, cursor and blank attribute
    logic [WORD_W-1:0]    screen [CELLS];
    int unsigned          cur_col;
    int unsigned          cur_row;
    logic [ATTR_W-1:0]    blank_attr;

    // results still owed by the block, oldest first
    t_result              expected_results [$];

    // run bookkeeping
    int unsigned          err_count       = 0;
    int unsigned          items_sent      = 0;
    int unsigned          results_checked = 0;
    int unsigned          scroll_count    = 0;
    int unsigned          clear_count     = 0;
    int unsigned          cfg_writes      = 0;

    // idling controls shared by the stimulus and the receiver
    bit                   in_idle_on   = 1'b1;
    bit                   out_idle_on  = 1'b1;
    int unsigned          out_hold_req = 0;
    bit                   out_holding  = 1'b0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_char_code       (i_char_code),
        .i_back_color      (i_back_color),
        .i_fore_color      (i_fore_color),
        .i_cell_index      (i_cell_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cell_word       (o_cell_word),
        .o_cursor_pos      (o_cursor_pos),
        .o_scrolled        (o_scrolled),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // fill a span of the predicted screen with blank cells
    function automatic void blank_cells(int unsigned from, int unsigned to);
        int unsigned i;
        for (i = from; i < to; i++) begin
            screen[i] = {blank_attr, CH_SPACE};
        end
    endfunction

    // screen predictor: applies one item and returns the result it causes
    function automatic t_result console_step(t_op op, logic [CHAR_W-1:0] ch,
            logic [COLOR_W-1:0] back, logic [COLOR_W-1:0] fore, logic [INDEX_W-1:0] idx);
        t_result     res;
        int unsigned pos;
        int unsigned i;
        res = '0;
        case (op)
            OP_PUT: begin
                if (ch == CH_BACKSPACE && cur_col != 0) begin
                    cur_col--;
                end else if (ch == CH_RETURN) begin
                    cur_col = 0;
                end else if (ch == CH_LINEFEED) begin
                    cur_col = 0;
                    cur_row++;
                end else if (ch >= CH_SPACE && ch <= CH_LAST_PRT) begin
                    pos = cur_row * COLUMNS + cur_col;
                    if (pos < CELLS) screen[pos] = {back, fore, ch};
                    cur_col++;
                end
                // line wrap at the last column
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // past the last row: shift everything up one row
                if (cur_row >= ROWS) begin
                    for (i = 0; i < CELLS - COLUMNS; i++) begin
                        screen[i] = screen[i + COLUMNS];
                    end
                    blank_cells(CELLS - COLUMNS, CELLS);
                    cur_row      = ROWS - 1;
                    res.scrolled = 1'b1;
                    scroll_count++;
                end
            end
            OP_CLEAR: begin
                blank_cells(0, CELLS);
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            OP_READ: begin
                if (idx < CELLS) res.cell_word = screen[idx];
            end
            default: ;
        endcase
        res.cursor_pos = INDEX_W'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    // offer one input beat, hold it until accepted, then log its expected result
    task automatic send_item(t_op op, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] back,
            logic [COLOR_W-1:0] fore, logic [INDEX_W-1:0] idx);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_char_code  <= ch;
        i_back_color <= back;
        i_fore_color <= fore;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(console_step(op, ch, back, fore, idx));
        items_sent++;
        // random sender gap
        if (in_idle_on && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_put(logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  11'($urandom_range(0, 2047)));
    endtask

    task automatic send_read(logic [INDEX_W-1:0] idx);
        send_item(OP_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), idx);
    endtask

    task automatic send_clear();
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // config beat, only sent while the block is idle
    task automatic write_blank_attr(logic [ATTR_W-1:0] attr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= attr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        blank_attr = attr;
        cfg_writes++;
    endtask

    // a byte that a put silently drops
    function automatic logic [CHAR_W-1:0] ignored_byte();
        logic [CHAR_W-1:0] ch;
        if ($urandom_range(0, 1) == 0) begin
            ch = 8'($urandom_range(8'h80, 8'hFF));
        end else begin
            ch = 8'($urandom_range(0, 8'h1F));
            if (ch == CH_BACKSPACE || ch == CH_LINEFEED || ch == CH_RETURN) ch = 8'h1B;
        end
        return ch;
    endfunction

    // byte inside a text line: mostly printable with some editing controls and junk
    function automatic logic [CHAR_W-1:0] line_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return CH_BACKSPACE;
        if (r < 8) return CH_RETURN;
        if (r < 12) return ignored_byte();
        return 8'($urandom_range(CH_SPACE, CH_LAST_PRT));
    endfunction

    // text traffic: lines ended by line feeds, with reads, clears and noise mixed in
    task automatic run_text_traffic(int unsigned n_items);
        int unsigned stop_at;
        int unsigned r;
        int unsigned len;
        int unsigned k;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_clear();
            end else if (r < 6) begin
                send_item(OP_NONE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
            end else if (r < 18) begin
                repeat ($urandom_range(1, 4)) send_read(11'($urandom_range(0, 2047)));
            end else if (r < 21) begin
                send_put(ignored_byte());
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(0, 25);
                for (k = 0; k < len; k++) send_put(line_byte());
                if ($urandom_range(0, 99) < 85) send_put(CH_LINEFEED);
            end
        end
    endtask

    // receiver stall: random bursts, calm stretches, and a long hold on request
    initial begin : out_stall_gen
        int unsigned span;
        forever begin
            @(posedge i_clk);
            if (out_hold_req != 0) begin
                span         = out_hold_req;
                out_hold_req = 0;
                out_holding  = 1'b1;
                i_out_stall <= 1'b1;
                repeat (span) @(posedge i_clk);
                i_out_stall <= 1'b0;
                out_holding  = 1'b0;
            end else if (out_idle_on && $urandom_range(0, 99) < 8) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 2) begin
                repeat ($urandom_range(30, 100)) @(posedge i_clk);
            end
        end
    end

    // compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: cell_word %h cursor %0d scrolled %0b",
                         $time, o_cell_word, o_cursor_pos, o_scrolled);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_cell_word !== want.cell_word) begin
                    $display("%0t: cell_word expected %h actual %h",
                             $time, want.cell_word, o_cell_word);
                    err_count++;
                end
                if (o_cursor_pos !== want.cursor_pos) begin
                    $display("%0t: cursor_pos expected %0d actual %0d",
                             $time, want.cursor_pos, o_cursor_pos);
                    err_count++;
                end
                if (o_scrolled !== want.scrolled) begin
                    $display("%0t: scrolled expected %0b actual %0b",
                             $time, want.scrolled, o_scrolled);
                    err_count++;
                end
            end
        end
    end

    // blank screen after reset, corners and reads past the store
    task automatic test_reset_state();
        send_read(11'd0);
        send_read(11'(CELLS - 1));
        send_read(11'(CELLS));
        send_read(11'h7FF);
    endtask

    // every character class and control byte of a put, the unused op, and a clear
    task automatic test_put_cases();
        send_item(OP_PUT, 8'h41, 4'h0, 4'h0, 11'd0);
        send_item(OP_PUT, CH_LAST_PRT, 4'hF, 4'hF, 11'h7FF);
        send_item(OP_PUT, CH_SPACE, 4'h5, 4'hA, 11'd0);
        send_item(OP_PUT, 8'h1F, 4'h3, 4'h3, 11'd0);
        send_item(OP_PUT, 8'h80, 4'h3, 4'h3, 11'd0);
        send_item(OP_PUT, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        send_item(OP_PUT, 8'h00, 4'h0, 4'h0, 11'd0);
        send_put(CH_BACKSPACE);
        send_put(CH_RETURN);
        send_put(CH_BACKSPACE);
        send_put(CH_LINEFEED);
        send_item(OP_NONE, 8'hFF, 4'hF, 4'hF, 11'h7FF);
        send_read(11'd0);
        send_read(11'd1);
        send_read(11'd2);
        send_clear();
        send_read(11'd0);
    endtask

    // walk to the bottom row, then scroll once by wrap and once by line feed
    task automatic test_bottom_row();
        int unsigned k;
        send_clear();
        repeat (ROWS - 1) send_put(CH_LINEFEED);
        for (k = 0; k < COLUMNS; k++) send_put(8'($urandom_range(CH_SPACE, CH_LAST_PRT)));
        send_read(11'((ROWS - 2) * COLUMNS));
        send_read(11'(CELLS - 1));
        send_put(8'h7E);
        send_put(CH_LINEFEED);
        send_read(11'((ROWS - 2) * COLUMNS));
        send_read(11'((ROWS - 1) * COLUMNS));
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_pressure();
        in_idle_on   = 1'b0;
        i_in_valid  <= 1'b0;
        out_hold_req = LONG_HOLD;
        while (!out_holding) @(posedge i_clk);
        repeat (24) send_put(8'($urandom_range(CH_SPACE, CH_LAST_PRT)));
        send_read(11'd0);
        in_idle_on = 1'b1;
    endtask

    // one phase of random text under a new blank attribute
    task automatic test_random_text(logic [ATTR_W-1:0] attr, int unsigned n_items);
        wait_drained();
        write_blank_attr(attr);
        run_text_traffic(n_items);
    endtask

    // closing stretch with no idling on either side
    task automatic test_full_rate(logic [ATTR_W-1:0] attr, int unsigned n_items);
        wait_drained();
        write_blank_attr(attr);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        run_text_traffic(n_items);
    endtask

    initial begin : main_sequence
        // predictor starts from the reset screen
        blank_attr = RESET_BLANK_ATTR;
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_put_cases();
        test_bottom_row();
        test_random_text(8'h00, 220);
        test_random_text(8'hFF, 220);
        test_random_text(8'($urandom_range(0, 255)), 100);
        test_output_pressure();
        test_random_text(8'($urandom_range(0, 255)), 200);
        test_full_rate(8'h5A, 150);

        wait_drained();
        repeat (32) @(posedge i_clk);
        while (expected_results.size() != 0) begin
            void'(expected_results.pop_front());
            $display("%0t: expected result never arrived", $time);
            err_count++;
        end

        $display("run covered %0d items and %0d checked results: %0d scrolls, %0d clears,",
                 items_sent, results_checked, scroll_count, clear_count);
        $display("%0d blank attribute writes, all put cases, unused op and output hold-off",
                 cfg_writes);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("timeout after %0d ns", RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_seq.sv
rtl/text_console_writer.sv
tb/testbench.sv
